// ===== rtl/aesd_pkg.sv =====
`default_nettype none
package aesd_pkg;

	localparam int unsigned RoundCountDefault = 10;

	localparam logic RegKeyHigh = 1'b0;
	localparam logic RegKeyLow  = 1'b1;

	typedef logic [127:0] block_t;

	function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sbox_inv(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r = 8'h52; 8'h01: r = 8'h09; 8'h02: r = 8'h6a; 8'h03: r = 8'hd5;
			8'h04: r = 8'h30; 8'h05: r = 8'h36; 8'h06: r = 8'ha5; 8'h07: r = 8'h38;
			8'h08: r = 8'hbf; 8'h09: r = 8'h40; 8'h0a: r = 8'ha3; 8'h0b: r = 8'h9e;
			8'h0c: r = 8'h81; 8'h0d: r = 8'hf3; 8'h0e: r = 8'hd7; 8'h0f: r = 8'hfb;
			8'h10: r = 8'h7c; 8'h11: r = 8'he3; 8'h12: r = 8'h39; 8'h13: r = 8'h82;
			8'h14: r = 8'h9b; 8'h15: r = 8'h2f; 8'h16: r = 8'hff; 8'h17: r = 8'h87;
			8'h18: r = 8'h34; 8'h19: r = 8'h8e; 8'h1a: r = 8'h43; 8'h1b: r = 8'h44;
			8'h1c: r = 8'hc4; 8'h1d: r = 8'hde; 8'h1e: r = 8'he9; 8'h1f: r = 8'hcb;
			8'h20: r = 8'h54; 8'h21: r = 8'h7b; 8'h22: r = 8'h94; 8'h23: r = 8'h32;
			8'h24: r = 8'ha6; 8'h25: r = 8'hc2; 8'h26: r = 8'h23; 8'h27: r = 8'h3d;
			8'h28: r = 8'hee; 8'h29: r = 8'h4c; 8'h2a: r = 8'h95; 8'h2b: r = 8'h0b;
			8'h2c: r = 8'h42; 8'h2d: r = 8'hfa; 8'h2e: r = 8'hc3; 8'h2f: r = 8'h4e;
			8'h30: r = 8'h08; 8'h31: r = 8'h2e; 8'h32: r = 8'ha1; 8'h33: r = 8'h66;
			8'h34: r = 8'h28; 8'h35: r = 8'hd9; 8'h36: r = 8'h24; 8'h37: r = 8'hb2;
			8'h38: r = 8'h76; 8'h39: r = 8'h5b; 8'h3a: r = 8'ha2; 8'h3b: r = 8'h49;
			8'h3c: r = 8'h6d; 8'h3d: r = 8'h8b; 8'h3e: r = 8'hd1; 8'h3f: r = 8'h25;
			8'h40: r = 8'h72; 8'h41: r = 8'hf8; 8'h42: r = 8'hf6; 8'h43: r = 8'h64;
			8'h44: r = 8'h86; 8'h45: r = 8'h68; 8'h46: r = 8'h98; 8'h47: r = 8'h16;
			8'h48: r = 8'hd4; 8'h49: r = 8'ha4; 8'h4a: r = 8'h5c; 8'h4b: r = 8'hcc;
			8'h4c: r = 8'h5d; 8'h4d: r = 8'h65; 8'h4e: r = 8'hb6; 8'h4f: r = 8'h92;
			8'h50: r = 8'h6c; 8'h51: r = 8'h70; 8'h52: r = 8'h48; 8'h53: r = 8'h50;
			8'h54: r = 8'hfd; 8'h55: r = 8'hed; 8'h56: r = 8'hb9; 8'h57: r = 8'hda;
			8'h58: r = 8'h5e; 8'h59: r = 8'h15; 8'h5a: r = 8'h46; 8'h5b: r = 8'h57;
			8'h5c: r = 8'ha7; 8'h5d: r = 8'h8d; 8'h5e: r = 8'h9d; 8'h5f: r = 8'h84;
			8'h60: r = 8'h90; 8'h61: r = 8'hd8; 8'h62: r = 8'hab; 8'h63: r = 8'h00;
			8'h64: r = 8'h8c; 8'h65: r = 8'hbc; 8'h66: r = 8'hd3; 8'h67: r = 8'h0a;
			8'h68: r = 8'hf7; 8'h69: r = 8'he4; 8'h6a: r = 8'h58; 8'h6b: r = 8'h05;
			8'h6c: r = 8'hb8; 8'h6d: r = 8'hb3; 8'h6e: r = 8'h45; 8'h6f: r = 8'h06;
			8'h70: r = 8'hd0; 8'h71: r = 8'h2c; 8'h72: r = 8'h1e; 8'h73: r = 8'h8f;
			8'h74: r = 8'hca; 8'h75: r = 8'h3f; 8'h76: r = 8'h0f; 8'h77: r = 8'h02;
			8'h78: r = 8'hc1; 8'h79: r = 8'haf; 8'h7a: r = 8'hbd; 8'h7b: r = 8'h03;
			8'h7c: r = 8'h01; 8'h7d: r = 8'h13; 8'h7e: r = 8'h8a; 8'h7f: r = 8'h6b;
			8'h80: r = 8'h3a; 8'h81: r = 8'h91; 8'h82: r = 8'h11; 8'h83: r = 8'h41;
			8'h84: r = 8'h4f; 8'h85: r = 8'h67; 8'h86: r = 8'hdc; 8'h87: r = 8'hea;
			8'h88: r = 8'h97; 8'h89: r = 8'hf2; 8'h8a: r = 8'hcf; 8'h8b: r = 8'hce;
			8'h8c: r = 8'hf0; 8'h8d: r = 8'hb4; 8'h8e: r = 8'he6; 8'h8f: r = 8'h73;
			8'h90: r = 8'h96; 8'h91: r = 8'hac; 8'h92: r = 8'h74; 8'h93: r = 8'h22;
			8'h94: r = 8'he7; 8'h95: r = 8'had; 8'h96: r = 8'h35; 8'h97: r = 8'h85;
			8'h98: r = 8'he2; 8'h99: r = 8'hf9; 8'h9a: r = 8'h37; 8'h9b: r = 8'he8;
			8'h9c: r = 8'h1c; 8'h9d: r = 8'h75; 8'h9e: r = 8'hdf; 8'h9f: r = 8'h6e;
			8'ha0: r = 8'h47; 8'ha1: r = 8'hf1; 8'ha2: r = 8'h1a; 8'ha3: r = 8'h71;
			8'ha4: r = 8'h1d; 8'ha5: r = 8'h29; 8'ha6: r = 8'hc5; 8'ha7: r = 8'h89;
			8'ha8: r = 8'h6f; 8'ha9: r = 8'hb7; 8'haa: r = 8'h62; 8'hab: r = 8'h0e;
			8'hac: r = 8'haa; 8'had: r = 8'h18; 8'hae: r = 8'hbe; 8'haf: r = 8'h1b;
			8'hb0: r = 8'hfc; 8'hb1: r = 8'h56; 8'hb2: r = 8'h3e; 8'hb3: r = 8'h4b;
			8'hb4: r = 8'hc6; 8'hb5: r = 8'hd2; 8'hb6: r = 8'h79; 8'hb7: r = 8'h20;
			8'hb8: r = 8'h9a; 8'hb9: r = 8'hdb; 8'hba: r = 8'hc0; 8'hbb: r = 8'hfe;
			8'hbc: r = 8'h78; 8'hbd: r = 8'hcd; 8'hbe: r = 8'h5a; 8'hbf: r = 8'hf4;
			8'hc0: r = 8'h1f; 8'hc1: r = 8'hdd; 8'hc2: r = 8'ha8; 8'hc3: r = 8'h33;
			8'hc4: r = 8'h88; 8'hc5: r = 8'h07; 8'hc6: r = 8'hc7; 8'hc7: r = 8'h31;
			8'hc8: r = 8'hb1; 8'hc9: r = 8'h12; 8'hca: r = 8'h10; 8'hcb: r = 8'h59;
			8'hcc: r = 8'h27; 8'hcd: r = 8'h80; 8'hce: r = 8'hec; 8'hcf: r = 8'h5f;
			8'hd0: r = 8'h60; 8'hd1: r = 8'h51; 8'hd2: r = 8'h7f; 8'hd3: r = 8'ha9;
			8'hd4: r = 8'h19; 8'hd5: r = 8'hb5; 8'hd6: r = 8'h4a; 8'hd7: r = 8'h0d;
			8'hd8: r = 8'h2d; 8'hd9: r = 8'he5; 8'hda: r = 8'h7a; 8'hdb: r = 8'h9f;
			8'hdc: r = 8'h93; 8'hdd: r = 8'hc9; 8'hde: r = 8'h9c; 8'hdf: r = 8'hef;
			8'he0: r = 8'ha0; 8'he1: r = 8'he0; 8'he2: r = 8'h3b; 8'he3: r = 8'h4d;
			8'he4: r = 8'hae; 8'he5: r = 8'h2a; 8'he6: r = 8'hf5; 8'he7: r = 8'hb0;
			8'he8: r = 8'hc8; 8'he9: r = 8'heb; 8'hea: r = 8'hbb; 8'heb: r = 8'h3c;
			8'hec: r = 8'h83; 8'hed: r = 8'h53; 8'hee: r = 8'h99; 8'hef: r = 8'h61;
			8'hf0: r = 8'h17; 8'hf1: r = 8'h2b; 8'hf2: r = 8'h04; 8'hf3: r = 8'h7e;
			8'hf4: r = 8'hba; 8'hf5: r = 8'h77; 8'hf6: r = 8'hd6; 8'hf7: r = 8'h26;
			8'hf8: r = 8'he1; 8'hf9: r = 8'h69; 8'hfa: r = 8'h14; 8'hfb: r = 8'h63;
			8'hfc: r = 8'h55; 8'hfd: r = 8'h21; 8'hfe: r = 8'h0c; 8'hff: r = 8'h7d;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] xtime_inv(input logic [7:0] v);
		return {v[0], v[7:1]} ^ (v[0] ? 8'h0d : 8'h00);
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEYF = 4'b0010,
		ST_RND  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic key_load;
		logic key_fwd;
		logic key_back;
	} key_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/aesd_key_unit.sv =====
`default_nettype none
module aesd_key_unit (
	input  wire logic               clk,
	input  wire aesd_pkg::key_ctl_t ctl,
	input  wire aesd_pkg::block_t   key,
	output aesd_pkg::block_t        rkey
);
	import aesd_pkg::*;

	block_t rk_q;
	logic [7:0] rc_q;
	logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3, p0, p1, p2, p3, tb;

	assign {w0, w1, w2, w3} = rk_q;
	assign t = {sbox_fwd(w3[23:16]), sbox_fwd(w3[15:8]), sbox_fwd(w3[7:0]),
		sbox_fwd(w3[31:24])} ^ {rc_q, 24'h0};
	assign n0 = w0 ^ t;
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;

	// Stepping back: recover the previous round key from the current one.
	assign p3 = w3 ^ w2;
	assign p2 = w2 ^ w1;
	assign p1 = w1 ^ w0;
	assign tb = {sbox_fwd(p3[23:16]), sbox_fwd(p3[15:8]), sbox_fwd(p3[7:0]),
		sbox_fwd(p3[31:24])} ^ {xtime_inv(rc_q), 24'h0};
	assign p0 = w0 ^ tb;

	always_ff @(posedge clk) begin
		if (ctl.key_load) begin
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (ctl.key_fwd) begin
			rk_q <= {n0, n1, n2, n3};
			rc_q <= xtime(rc_q);
		end else if (ctl.key_back) begin
			rk_q <= {p0, p1, p2, p3};
			rc_q <= xtime_inv(rc_q);
		end
	end

	assign rkey = rk_q;
endmodule
`default_nettype wire

// ===== rtl/aesd_round_unit.sv =====
`default_nettype none
module aesd_round_unit (
	input  wire aesd_pkg::block_t state,
	input  wire aesd_pkg::block_t rkey,
	input  wire logic             mix,
	output aesd_pkg::block_t      next
);
	import aesd_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a0, a1, a2, a3;
	logic [7:0] x0 [4];
	logic [7:0] x1 [4];
	logic [7:0] x2 [4];
	logic [7:0] x3 [4];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state[127 - 8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c + r] = sbox_inv(s[4*((c - r + 4) % 4) + r]) ^ rkey[127 - 8*(4*c + r) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				x0[r] = t[4*c + r];
				x1[r] = xtime(x0[r]);
				x2[r] = xtime(x1[r]);
				x3[r] = xtime(x2[r]);
			end
			for (int r = 0; r < 4; r++) begin
				a0 = x3[r] ^ x2[r] ^ x1[r];
				a1 = x3[(r+1)%4] ^ x1[(r+1)%4] ^ x0[(r+1)%4];
				a2 = x3[(r+2)%4] ^ x2[(r+2)%4] ^ x0[(r+2)%4];
				a3 = x3[(r+3)%4] ^ x0[(r+3)%4];
				m[4*c + r] = a0 ^ a1 ^ a2 ^ a3;
			end
		end
		for (int i = 0; i < 16; i++) begin
			next[127 - 8*i -: 8] = mix ? m[i] : t[i];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/aes128_block_decrypt.sv =====
`default_nettype none
// AES-128 block decryption, one block at a time.
// Load the key through the write port: index 0 takes key bits 127:64, index 1
// takes bits 63:0. Write only while busy is low; a new key applies to the
// next block.
// Pulse start with cipher_high and cipher_low while busy is low to accept a
// word. Busy rises on the next cycle and stays high until the result is shown.
// The block first steps the key schedule forward nine times to reach round key
// nine, and then adds the last round key to the word. It then runs ten
// inverse rounds on one shared round unit, stepping the key schedule backward
// each round. done rises when the last round is through; busy falls in the
// cycle after done, and only then is the next start accepted.
// done is high for exactly one cycle with plain_high and plain_low; the
// outputs hold their value afterwards, and the receiver cannot stall.
// After reset the key is zero, busy and done are low.
module aes128_block_decrypt #(
	parameter int unsigned ROUND_COUNT = aesd_pkg::RoundCountDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] cipher_high,
	input  wire logic [63:0] cipher_low,
	output logic             done,
	output logic [63:0]      plain_high,
	output logic [63:0]      plain_low,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);
	import aesd_pkg::*;

	localparam int CntW = $clog2(ROUND_COUNT + 1);

	state_t state_q;
	logic [CntW-1:0] cnt_q;
	logic [63:0] key_hi_q, key_lo_q;
	block_t data_q, rkey, rnext;
	key_ctl_t kctl;
	logic last;
	logic keyf_last;

	aesd_key_unit u_key (
		.clk  (clk),
		.ctl  (kctl),
		.key  ({key_hi_q, key_lo_q}),
		.rkey (rkey)
	);

	aesd_round_unit u_rnd (
		.state (data_q),
		.rkey  (rkey),
		.mix   (cnt_q != CntW'(ROUND_COUNT - 1)),
		.next  (rnext)
	);

	assign last = (cnt_q == CntW'(ROUND_COUNT - 1));
	assign keyf_last = (state_q == ST_KEYF) && (cnt_q == CntW'(ROUND_COUNT - 1));
	assign kctl = '{
		key_load: (state_q == ST_IDLE) && start,
		key_fwd:  (state_q == ST_KEYF) && !keyf_last,
		key_back: (state_q == ST_RND)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegKeyHigh: key_hi_q <= cfg_data;
				RegKeyLow:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_KEYF;
						cnt_q   <= '0;
					end
				end
				ST_KEYF: begin
					if (cnt_q == CntW'(ROUND_COUNT - 1)) begin
						state_q <= ST_RND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RND: begin
					if (last) begin
						state_q <= ST_DONE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	function automatic block_t key_step_last(input block_t k);
		logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {sbox_fwd(w3[23:16]), sbox_fwd(w3[15:8]), sbox_fwd(w3[7:0]),
			sbox_fwd(w3[31:24])} ^ {8'h36, 24'h0};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// In the last key cycle round key nine is present; add the last round key.
	always_ff @(posedge clk) begin
		if (kctl.key_load) begin
			data_q <= {cipher_high, cipher_low};
		end else if (keyf_last) begin
			data_q <= data_q ^ key_step_last(rkey);
		end else if (state_q == ST_RND) begin
			data_q <= rnext;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign plain_high = data_q[127:64];
	assign plain_low  = data_q[63:0];

`ifndef SYNTHESIS
	a_done_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RND)) else $error("done without final round");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !done) |=> busy) else $error("busy dropped early");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
`endif
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} key_reg_t;

	class aes_decrypt_scoreboard;
		logic [7:0]   fwd_sub [256];
		logic [7:0]   inv_sub [256];
		logic [63:0]  key_hi;
		logic [63:0]  key_lo;
		logic [127:0] plain_queue [$];
		int           failures;
		int           words_checked;

		function new();
			logic [7:0] b;
			logic [7:0] x;
			key_hi = '0;
			key_lo = '0;
			failures = 0;
			words_checked = 0;
			for (int i = 0; i < 256; i++) begin
				b = 8'h00;
				for (int j = 1; j < 256; j++) begin
					if (gmul(i[7:0], j[7:0]) == 8'h01) begin
						b = j[7:0];
					end
				end
				x = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
					^ {b[3:0], b[7:4]} ^ 8'h63;
				fwd_sub[i] = x;
				inv_sub[x] = i[7:0];
			end
		endfunction

		function logic [7:0] gmul(logic [7:0] a, logic [7:0] m);
			logic [7:0] acc;
			acc = 8'h00;
			for (int k = 0; k < 8; k++) begin
				if (m[k]) begin
					acc ^= a;
				end
				a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			end
			return acc;
		endfunction

		function void set_key(key_reg_t idx, logic [63:0] value);
			if (idx == REG_KEY_HIGH) begin
				key_hi = value;
			end else begin
				key_lo = value;
			end
		endfunction

		function logic [127:0] decrypt(logic [127:0] cipher);
			logic [31:0] w [44];
			logic [31:0] t;
			logic [7:0]  rcon;
			logic [7:0]  s [16];
			logic [7:0]  n [16];
			logic [127:0] result;
			rcon = 8'h01;
			w[0] = key_hi[63:32];
			w[1] = key_hi[31:0];
			w[2] = key_lo[63:32];
			w[3] = key_lo[31:0];
			for (int i = 4; i < 44; i++) begin
				t = w[i - 1];
				if (i % 4 == 0) begin
					t = {t[23:0], t[31:24]};
					t = {fwd_sub[t[31:24]] ^ rcon, fwd_sub[t[23:16]],
						fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
					rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
				end
				w[i] = w[i - 4] ^ t;
			end
			for (int i = 0; i < 16; i++) begin
				s[i] = cipher[127 - 8 * i -: 8];
			end
			for (int rnd = 10; rnd >= 0; rnd--) begin
				if (rnd < 10) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) begin
							n[4 * c + r] = inv_sub[s[4 * ((c - r + 4) % 4) + r]];
						end
					end
					s = n;
				end
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) begin
						s[4 * c + r] ^= w[4 * rnd + c][31 - 8 * r -: 8];
					end
				end
				if (rnd > 0 && rnd < 10) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) begin
							n[4 * c + r] = gmul(s[4 * c + r], 8'h0e)
								^ gmul(s[4 * c + (r + 1) % 4], 8'h0b)
								^ gmul(s[4 * c + (r + 2) % 4], 8'h0d)
								^ gmul(s[4 * c + (r + 3) % 4], 8'h09);
						end
					end
					s = n;
				end
			end
			for (int i = 0; i < 16; i++) begin
				result[127 - 8 * i -: 8] = s[i];
			end
			return result;
		endfunction

		function void note_cipher(logic [63:0] hi, logic [63:0] lo);
			plain_queue.push_back(decrypt({hi, lo}));
		endfunction

		function void check_plain(logic [63:0] hi, logic [63:0] lo);
			logic [127:0] exp_plain;
			if (plain_queue.size() == 0) begin
				failures++;
				$display("%0t: unexpected word plain=%h%h", $time, hi, lo);
				return;
			end
			exp_plain = plain_queue.pop_front();
			words_checked++;
			if (hi !== exp_plain[127:64]) begin
				failures++;
				$display("%0t: plain_high expected %h actual %h", $time,
					exp_plain[127:64], hi);
			end
			if (lo !== exp_plain[63:0]) begin
				failures++;
				$display("%0t: plain_low expected %h actual %h", $time,
					exp_plain[63:0], lo);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	logic        done;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;

	aes_decrypt_scoreboard plain_check;
	int idle_pct;
	int stall_cycles;
	int key_writes;

	aes128_block_decrypt i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cipher_high (cipher_high),
		.cipher_low  (cipher_low),
		.done        (done),
		.plain_high  (plain_high),
		.plain_low   (plain_low),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			plain_check.check_plain(plain_high, plain_low);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= 3000) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(logic [63:0] hi, logic [63:0] lo);
		while (busy) @(negedge clk);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		start = 1'b1;
		cipher_high = hi;
		cipher_low = lo;
		@(posedge clk);
		plain_check.note_cipher(hi, lo);
		@(negedge clk);
		start = 1'b0;
		cipher_high = rand64();
		cipher_low = rand64();
	endtask

	task automatic write_key(logic [63:0] hi, logic [63:0] lo);
		while (plain_check.plain_queue.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		for (int k = 0; k < 2; k++) begin
			cfg_we = 1'b1;
			cfg_index = (k == 0) ? REG_KEY_HIGH : REG_KEY_LOW;
			cfg_data = (k == 0) ? hi : lo;
			@(posedge clk);
			plain_check.set_key(key_reg_t'(cfg_index), cfg_data);
			key_writes++;
			@(negedge clk);
			cfg_we = 1'b0;
		end
	endtask

	initial begin
		int pct [4];
		plain_check = new();
		pct = '{0, 64, 0, 10};
		idle_pct = 0;
		stall_cycles = 0;
		key_writes = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cipher_high = '0;
		cipher_low = '0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The zero key from reset is used first, then the standard test key.
		send_word('0, '0);
		send_word('1, '1);
		send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		send_word(64'h8000000000000000, 64'h0000000000000001);
		write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_word(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_word('0, '1);
		send_word('1, '0);
		write_key('1, '1);
		send_word('0, '0);
		send_word('1, '1);
		send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
		write_key(64'h8000000000000000, 64'h0000000000000001);
		send_word('0, '0);
		send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pct[ph];
			for (int blk = 0; blk < 5; blk++) begin
				case ($urandom_range(7))
					0: write_key('0, '0);
					1: write_key('1, '1);
					default: write_key(rand64(), rand64());
				endcase
				for (int i = 0; i < 97; i++) begin
					send_word(rand64(), rand64());
				end
			end
		end

		while (plain_check.plain_queue.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("Decrypted %0d words under %0d key register writes,",
			plain_check.words_checked, key_writes);
		$display("with sender gaps of 0, 10 and 64 percent.");
		if (plain_check.failures == 0 && plain_check.plain_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/aesd_pkg.sv
rtl/aesd_key_unit.sv
rtl/aesd_round_unit.sv
rtl/aes128_block_decrypt.sv
test/testbench.sv
